FILE: hdl/dodq_pkg.sv
package dodq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;
  localparam int TIME_BITS      = 64;
  localparam int PAYLOAD_BITS   = 32;

  typedef enum logic [1:0] {
    FUNC_ENQUEUE = 2'd0,
    FUNC_DEQUEUE = 2'd1,
    FUNC_CLOSE   = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_REJ_CLOSED = 3'd1,
    ST_REJ_FULL   = 3'd2,
    ST_RELEASED   = 3'd3,
    ST_NOT_DUE    = 3'd4,
    ST_EMPTY      = 3'd5,
    ST_END        = 3'd6
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                 insert;
    logic                 pop;
    logic [TIME_BITS-1:0] new_due;
  } cell_cmd_t;

endpackage

FILE: hdl/deadline_ordered_delay_queue_core.sv
// Channel   Signals                                       Direction
// input     in_valid, in_stall, func, payload,            into the block
//           due_time, now_time
// output    out_valid, out_stall, status, released_value  out of the block
//
// The whole cell chain shifts or loads in the same edge that accepts a
// transaction, and the result sits in an output register. A new transaction
// is taken while the output register is empty or being emptied. Reset clears
// all cell valid bits, the closed flag and the output valid. A stall on the
// output holds the result and stalls the input only while that result waits.
module deadline_ordered_delay_queue_core
  import dodq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              func,
  input  logic [PAYLOAD_BITS-1:0] payload,
  input  logic [TIME_BITS-1:0]    due_time,
  input  logic [TIME_BITS-1:0]    now_time,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              status,
  output logic [PAYLOAD_BITS-1:0] released_value
);

  logic                  cell_valid [DEPTH];
  logic                  cell_yield [DEPTH];
  logic [TIME_BITS-1:0]  cell_due   [DEPTH];
  logic [VALUE_BITS-1:0] cell_value [DEPTH];

  logic                  closed;
  logic                  closed_next;
  logic                  out_valid_next;
  logic                  fire;
  cell_cmd_t             cmd;
  status_t               result;
  logic [PAYLOAD_BITS-1:0] result_value;
  logic [63:0]           payload_wide;
  logic [63:0]           head_wide;
  logic [VALUE_BITS-1:0] new_value;
  logic                  full;
  logic                  empty;

  assign in_stall = out_valid && out_stall;
  assign fire     = in_valid && !in_stall;

  assign payload_wide = {32'b0, payload};
  assign new_value    = payload_wide[VALUE_BITS-1:0];
  assign head_wide    = 64'(cell_value[0]);
  assign full         = cell_valid[DEPTH-1];
  assign empty        = !cell_valid[0];

  always_comb begin
    cmd.insert   = 1'b0;
    cmd.pop      = 1'b0;
    cmd.new_due  = due_time;
    closed_next  = closed;
    result       = ST_REJ_CLOSED;
    result_value = '0;
    unique case (func_t'(func))
      FUNC_ENQUEUE: begin
        if (closed) begin
          result = ST_REJ_CLOSED;
        end else if (full) begin
          result = ST_REJ_FULL;
        end else begin
          result     = ST_STORED;
          cmd.insert = fire;
        end
      end
      FUNC_DEQUEUE: begin
        if (empty) begin
          result = closed ? ST_END : ST_EMPTY;
        end else if (cell_due[0] > now_time) begin
          result = ST_NOT_DUE;
        end else begin
          result       = ST_RELEASED;
          result_value = head_wide[PAYLOAD_BITS-1:0];
          cmd.pop      = fire;
        end
      end
      FUNC_CLOSE: begin
        result      = ST_END;
        closed_next = fire ? 1'b1 : closed;
      end
      FUNC_UNUSED: begin
        result = ST_REJ_CLOSED;
      end
      default: begin
        result = ST_REJ_CLOSED;
      end
    endcase
    out_valid_next = fire || (out_valid && out_stall);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  l_valid;
    logic                  l_yield;
    logic [TIME_BITS-1:0]  l_due;
    logic [VALUE_BITS-1:0] l_value;
    logic                  r_valid;
    logic [TIME_BITS-1:0]  r_due;
    logic [VALUE_BITS-1:0] r_value;

    if (i == 0) begin : g_first
      assign l_valid = 1'b0;
      assign l_yield = 1'b0;
      assign l_due   = '0;
      assign l_value = '0;
    end else begin : g_inner_l
      assign l_valid = cell_valid[i-1];
      assign l_yield = cell_yield[i-1];
      assign l_due   = cell_due[i-1];
      assign l_value = cell_value[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign r_valid = 1'b0;
      assign r_due   = '0;
      assign r_value = '0;
    end else begin : g_inner_r
      assign r_valid = cell_valid[i+1];
      assign r_due   = cell_due[i+1];
      assign r_value = cell_value[i+1];
    end

    dodq_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .new_value  (new_value),
      .left_valid (l_valid),
      .left_yield (l_yield),
      .left_due   (l_due),
      .left_value (l_value),
      .right_valid(r_valid),
      .right_due  (r_due),
      .right_value(r_value),
      .valid      (cell_valid[i]),
      .yield      (cell_yield[i]),
      .due        (cell_due[i]),
      .value      (cell_value[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      closed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      closed    <= closed_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status         <= result;
      released_value <= result_value;
    end
  end

endmodule

FILE: hdl/dodq_cell.sv
module dodq_cell
  import dodq_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_cmd_t             cmd,
  input  logic [VALUE_BITS-1:0] new_value,
  input  logic                  left_valid,
  input  logic                  left_yield,
  input  logic [TIME_BITS-1:0]  left_due,
  input  logic [VALUE_BITS-1:0] left_value,
  input  logic                  right_valid,
  input  logic [TIME_BITS-1:0]  right_due,
  input  logic [VALUE_BITS-1:0] right_value,
  output logic                  valid,
  output logic                  yield,
  output logic [TIME_BITS-1:0]  due,
  output logic [VALUE_BITS-1:0] value
);

  // A cell yields its place when it is empty or its entry is due strictly
  // later than the new one, so equal due times keep the older entry ahead.
  assign yield = !valid || (due > cmd.new_due);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.insert) begin
      if (left_yield) begin
        valid <= left_valid;
      end else if (yield) begin
        valid <= 1'b1;
      end
    end else if (cmd.pop) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (left_yield) begin
        due   <= left_due;
        value <= left_value;
      end else if (yield) begin
        due   <= cmd.new_due;
        value <= new_value;
      end
    end else if (cmd.pop) begin
      due   <= right_due;
      value <= right_value;
    end
  end

endmodule

FILE: hdl/dodq_checker.sv
module dodq_props
  import dodq_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [1:0]              func,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [2:0]              status,
  input logic [PAYLOAD_BITS-1:0] released_value
);

  // The input stalls only while a result waits in the output register.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // A held result stays valid.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // Only a release carries a payload.
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_RELEASED |-> released_value == '0)
    else $error("nonzero value without release");

  // An accepted close is answered in the next cycle with end of data.
  a_close_ack: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == FUNC_CLOSE |=> out_valid && status == ST_END)
    else $error("close not acknowledged");

  // Every result carries one of the defined status codes.
  a_no_store_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_END)
    else $error("undefined status code");

endmodule

bind deadline_ordered_delay_queue_core dodq_props u_dodq_props (.*);

FILE: tb/dodq_checker.sv
module dodq_checker
  import dodq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [1:0]              func,
  input  logic [PAYLOAD_BITS-1:0] payload,
  input  logic [TIME_BITS-1:0]    due_time,
  input  logic [TIME_BITS-1:0]    now_time,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [2:0]              status,
  input  logic [PAYLOAD_BITS-1:0] released_value,
  output int                      fail_count,
  output int                      pending
);

  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the queue, kept sorted by due time with the head at index zero.
  logic [PAYLOAD_BITS-1:0] held_value [DEPTH_DEF];
  logic [TIME_BITS-1:0]    held_due   [DEPTH_DEF];
  int                      held_count;
  bit                      is_closed;

  status_t                 result_status_q [$];
  logic [PAYLOAD_BITS-1:0] result_value_q  [$];
  int                      errs = 0;

  task automatic apply_queue_op(
    input  logic [1:0]              f,
    input  logic [PAYLOAD_BITS-1:0] pl,
    input  logic [TIME_BITS-1:0]    due,
    input  logic [TIME_BITS-1:0]    now_v,
    output status_t                 st,
    output logic [PAYLOAD_BITS-1:0] rv
  );
    int pos;
    rv = '0;
    case (func_t'(f))
      FUNC_ENQUEUE: begin
        if (is_closed) begin
          st = ST_REJ_CLOSED;
        end else if (held_count >= DEPTH_DEF) begin
          st = ST_REJ_FULL;
        end else begin
          // Entries with an equal due time stay ahead of the new one.
          pos = held_count;
          while (pos > 0 && held_due[pos-1] > due) begin
            held_value[pos] = held_value[pos-1];
            held_due[pos]   = held_due[pos-1];
            pos--;
          end
          held_value[pos] = pl;
          held_due[pos]   = due;
          held_count++;
          st = ST_STORED;
        end
      end
      FUNC_DEQUEUE: begin
        if (held_count == 0) begin
          st = is_closed ? ST_END : ST_EMPTY;
        end else if (held_due[0] > now_v) begin
          st = ST_NOT_DUE;
        end else begin
          rv = held_value[0];
          for (int i = 1; i < held_count; i++) begin
            held_value[i-1] = held_value[i];
            held_due[i-1]   = held_due[i];
          end
          held_count--;
          st = ST_RELEASED;
        end
      end
      FUNC_CLOSE: begin
        is_closed = 1'b1;
        st = ST_END;
      end
      default: begin
        st = ST_REJ_CLOSED;
      end
    endcase
  endtask

  always @(posedge clk) begin
    status_t                 st;
    logic [PAYLOAD_BITS-1:0] rv;
    if (rst) begin
      held_count = 0;
      is_closed  = 1'b0;
      result_status_q.delete();
      result_value_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        apply_queue_op(func, payload, due_time, now_time, st, rv);
        result_status_q.push_back(st);
        result_value_q.push_back(rv);
      end
      if (out_valid && !out_stall) begin
        if (result_status_q.size() == 0) begin
          errs++;
          if (errs <= REPORT_LIMIT)
            $display("unexpected result: status %0d value %h", status, released_value);
        end else begin
          st = result_status_q.pop_front();
          rv = result_value_q.pop_front();
          if (status !== st || released_value !== rv) begin
            errs++;
            if (errs <= REPORT_LIMIT)
              $display({"result mismatch: expected status %0d value %h, ",
                        "got status %0d value %h"},
                       st, rv, status, released_value);
          end
        end
      end
    end
    pending    <= result_status_q.size();
    fail_count <= errs;
  end

endmodule

FILE: tb/tb_deadline_ordered_delay_queue_core.sv
module tb_deadline_ordered_delay_queue_core;
  import dodq_pkg::*;

  localparam int STALL_PCT      = 27;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int CLOSED_ITEMS   = 60;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_START     = 300;
  localparam int HOLD_CYCLES    = 120;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              func;
  logic [PAYLOAD_BITS-1:0] payload;
  logic [TIME_BITS-1:0]    due_time;
  logic [TIME_BITS-1:0]    now_time;
  logic                    out_valid;
  logic                    out_stall;
  logic [2:0]              status;
  logic [PAYLOAD_BITS-1:0] released_value;

  int                      fail_count;
  int                      pending;
  int                      cyc = 0;
  int                      quiet_count = 0;
  logic                    calm;
  logic [TIME_BITS-1:0]    sim_clock_val;

  // Neither side idles inside this window.
  assign calm = (cyc >= 1200) && (cyc < 2200);

  deadline_ordered_delay_queue_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .payload        (payload),
    .due_time       (due_time),
    .now_time       (now_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .released_value (released_value)
  );

  dodq_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .payload        (payload),
    .due_time       (due_time),
    .now_time       (now_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .released_value (released_value),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // Ends the run when neither channel has moved a transaction for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count >= WATCHDOG_LIMIT) begin
        $display("tb_deadline_ordered_delay_queue_core: FAIL");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off that backs up into the input.
  initial begin
    int rx_cycles;
    rx_cycles = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rx_cycles == HOLD_START) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < STALL_PCT);
      end
    end
  end

  task automatic put_op(
    input func_t                   f,
    input logic [PAYLOAD_BITS-1:0] pl,
    input logic [TIME_BITS-1:0]    due,
    input logic [TIME_BITS-1:0]    now_v
  );
    while (!calm && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    payload  <= pl;
    due_time <= due;
    now_time <= now_v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Due times cluster just ahead of a slowly advancing clock so that entries
  // become due in a mix of orders, with occasional extreme or wild values.
  task automatic put_random(input int enq_w, input bit allow_close);
    int                   r;
    func_t                f;
    logic [TIME_BITS-1:0] due;
    logic [TIME_BITS-1:0] now_v;
    r = $urandom_range(99);
    if (r < 3)
      f = FUNC_UNUSED;
    else if (allow_close && r < 6)
      f = FUNC_CLOSE;
    else if (r < 6 + enq_w)
      f = FUNC_ENQUEUE;
    else
      f = FUNC_DEQUEUE;
    due = sim_clock_val + $urandom_range(0, 40);
    r = $urandom_range(99);
    if (r < 4)
      due = {$urandom, $urandom};
    else if (r < 6)
      due = '0;
    else if (r < 8)
      due = '1;
    sim_clock_val = sim_clock_val + $urandom_range(0, 12);
    now_v = sim_clock_val;
    r = $urandom_range(99);
    if (r < 4)
      now_v = {$urandom, $urandom};
    else if (r < 6)
      now_v = '0;
    else if (r < 7)
      now_v = '1;
    put_op(f, $urandom, due, now_v);
  endtask

  initial begin
    int enq_w;
    rst           = 1'b1;
    in_valid      = 1'b0;
    func          = FUNC_ENQUEUE;
    payload       = '0;
    due_time      = '0;
    now_time      = '0;
    sim_clock_val = '0;
    enq_w         = 47;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty and open, the unused selector, and the extremes of both time fields.
    put_op(FUNC_DEQUEUE, '0, '0, '0);
    put_op(FUNC_UNUSED, '1, '1, '1);
    put_op(FUNC_ENQUEUE, '0, '1, '0);
    put_op(FUNC_ENQUEUE, '1, '0, '1);
    put_op(FUNC_DEQUEUE, '0, '0, '0);
    put_op(FUNC_DEQUEUE, '1, '1, '0);
    put_op(FUNC_DEQUEUE, '0, '0, '1);
    // Fill with a run of equal due times followed by falling ones, then one enqueue too many.
    for (int k = 0; k < DEPTH_DEF; k++)
      put_op(FUNC_ENQUEUE, 32'h100 + k, (k < 8) ? 64'd50 : 64'd100 - k, '0);
    put_op(FUNC_ENQUEUE, 32'hdead_beef, '0, '0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       enq_w = 20;
          1:       enq_w = 47;
          default: enq_w = 75;
        endcase
        if ($urandom_range(9) == 0)
          sim_clock_val = {$urandom, $urandom} >> 1;
      end
      put_random(enq_w, 1'b0);
    end

    // Drain, refill to full, then close: the closed flag outranks full.
    for (int k = 0; k < DEPTH_DEF + 2; k++)
      put_op(FUNC_DEQUEUE, '0, '0, '1);
    for (int k = 0; k < DEPTH_DEF; k++)
      put_op(FUNC_ENQUEUE, $urandom, 64'd1000 + $urandom_range(0, 5), '0);
    put_op(FUNC_ENQUEUE, $urandom, '0, '0);
    put_op(FUNC_CLOSE, '0, '0, '0);
    put_op(FUNC_ENQUEUE, $urandom, '0, '0);
    put_op(FUNC_DEQUEUE, '0, '0, 64'd999);
    for (int k = 0; k < DEPTH_DEF; k++)
      put_op(FUNC_DEQUEUE, '0, '0, 64'd1005);
    put_op(FUNC_DEQUEUE, '0, '0, '1);
    put_op(FUNC_CLOSE, '1, '1, '1);
    put_op(FUNC_UNUSED, '0, '0, '0);
    for (int i = 0; i < CLOSED_ITEMS; i++)
      put_random(47, 1'b1);
    in_valid <= 1'b0;

    // Let the count of outstanding results catch up with the last transaction.
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_deadline_ordered_delay_queue_core: PASS");
    end else begin
      $display("tb_deadline_ordered_delay_queue_core: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/dodq_pkg.sv
hdl/dodq_cell.sv
hdl/deadline_ordered_delay_queue_core.sv
hdl/dodq_checker.sv
tb/dodq_checker.sv
tb/tb_deadline_ordered_delay_queue_core.sv
